@@ rtl/nmt_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes of the NAT mapping table.
// Used by the channel interfaces, the table cell and the top level.
package nmt_pkg;

  localparam int OP_W     = 2;
  localparam int ST_W     = 2;
  localparam int ADDR_W   = 32;
  localparam int PORT_W   = 16;
  localparam int STAMP_W  = 32;

  localparam logic [OP_W-1:0] OP_LOOKUP_OUTER = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP_INNER = 2'd1;
  localparam logic [OP_W-1:0] OP_INSERT       = 2'd2;

  localparam logic [ST_W-1:0] ST_HIT      = 2'd0;
  localparam logic [ST_W-1:0] ST_MISS     = 2'd1;
  localparam logic [ST_W-1:0] ST_INSERTED = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd3;

  // Request token that walks the row of cells. The entry fields start as the
  // request and are replaced by the stored entry at a lookup hit.
  typedef struct packed {
    logic               valid;
    logic               done;
    logic [ST_W-1:0]    status;
    logic [OP_W-1:0]    opcode;
    logic               map_type;
    logic [ADDR_W-1:0]  inner_addr;
    logic [PORT_W-1:0]  inner_port;
    logic [ADDR_W-1:0]  outer_addr;
    logic [PORT_W-1:0]  outer_port;
    logic [STAMP_W-1:0] now_stamp;
  } tok_t;

endpackage

@@ rtl/nmt_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channels of the NAT mapping table: request and response words.
// Depends on nmt_pkg for field widths.
interface nmt_req_if;
  logic                        valid;
  logic                        ready;
  logic [nmt_pkg::OP_W-1:0]    opcode;
  logic                        map_type;
  logic [nmt_pkg::ADDR_W-1:0]  inner_addr;
  logic [nmt_pkg::PORT_W-1:0]  inner_port;
  logic [nmt_pkg::ADDR_W-1:0]  outer_addr;
  logic [nmt_pkg::PORT_W-1:0]  outer_port;
  logic [nmt_pkg::STAMP_W-1:0] now_stamp;

  modport source (output valid, opcode, map_type, inner_addr, inner_port, outer_addr,
                  outer_port, now_stamp, input ready);
  modport sink   (input valid, opcode, map_type, inner_addr, inner_port, outer_addr,
                  outer_port, now_stamp, output ready);
endinterface

interface nmt_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [nmt_pkg::ST_W-1:0]    status;
  logic                        found_type;
  logic [nmt_pkg::ADDR_W-1:0]  found_inner_addr;
  logic [nmt_pkg::PORT_W-1:0]  found_inner_port;
  logic [nmt_pkg::ADDR_W-1:0]  found_outer_addr;
  logic [nmt_pkg::PORT_W-1:0]  found_outer_port;
  logic [nmt_pkg::STAMP_W-1:0] found_stamp;

  modport source (output valid, status, found_type, found_inner_addr, found_inner_port,
                  found_outer_addr, found_outer_port, found_stamp, input ready);
  modport sink   (input valid, status, found_type, found_inner_addr, found_inner_port,
                  found_outer_addr, found_outer_port, found_stamp, output ready);
endinterface

@@ rtl/nmt_cell.sv @@
`timescale 1ns / 1ps
// One table slot: holds a mapping entry and acts on the token passing by.
// Depends on nmt_pkg for the token type and codes.
module nmt_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  nmt_pkg::tok_t tok_in,
  output nmt_pkg::tok_t tok_out
);

  logic                        entry_valid;
  logic                        entry_type;
  logic [nmt_pkg::ADDR_W-1:0]  entry_inner_addr;
  logic [nmt_pkg::PORT_W-1:0]  entry_inner_port;
  logic [nmt_pkg::ADDR_W-1:0]  entry_outer_addr;
  logic [nmt_pkg::PORT_W-1:0]  entry_outer_port;
  logic [nmt_pkg::STAMP_W-1:0] entry_stamp;

  nmt_pkg::tok_t tok_next;
  logic          key_match;
  logic          active;
  logic          do_hit;
  logic          do_insert;

  always_comb begin
    case (tok_in.opcode)
      nmt_pkg::OP_LOOKUP_OUTER: key_match = entry_outer_port == tok_in.outer_port;
      nmt_pkg::OP_LOOKUP_INNER: key_match = entry_inner_addr == tok_in.inner_addr &&
                                            entry_inner_port == tok_in.inner_port;
      default:                  key_match = 1'b0;
    endcase
  end

  assign active    = advance && tok_in.valid && !tok_in.done;
  assign do_hit    = active && entry_valid && entry_type == tok_in.map_type && key_match;
  assign do_insert = active && !entry_valid && tok_in.opcode == nmt_pkg::OP_INSERT;

  always_comb begin
    tok_next = tok_in;
    if (do_hit) begin
      tok_next.done       = 1'b1;
      tok_next.status     = nmt_pkg::ST_HIT;
      tok_next.map_type   = entry_type;
      tok_next.inner_addr = entry_inner_addr;
      tok_next.inner_port = entry_inner_port;
      tok_next.outer_addr = entry_outer_addr;
      tok_next.outer_port = entry_outer_port;
    end else if (do_insert) begin
      tok_next.done   = 1'b1;
      tok_next.status = nmt_pkg::ST_INSERTED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid   <= 1'b0;
      tok_out.valid <= 1'b0;
    end else begin
      if (do_insert) begin
        entry_valid <= 1'b1;
      end
      if (advance) begin
        tok_out.valid <= tok_in.valid;
      end
    end
    // Payload needs no reset.
    if (advance) begin
      tok_out.done       <= tok_next.done;
      tok_out.status     <= tok_next.status;
      tok_out.opcode     <= tok_next.opcode;
      tok_out.map_type   <= tok_next.map_type;
      tok_out.inner_addr <= tok_next.inner_addr;
      tok_out.inner_port <= tok_next.inner_port;
      tok_out.outer_addr <= tok_next.outer_addr;
      tok_out.outer_port <= tok_next.outer_port;
      tok_out.now_stamp  <= tok_next.now_stamp;
    end
    if (do_insert) begin
      entry_type       <= tok_in.map_type;
      entry_inner_addr <= tok_in.inner_addr;
      entry_inner_port <= tok_in.inner_port;
      entry_outer_addr <= tok_in.outer_addr;
      entry_outer_port <= tok_in.outer_port;
    end
    // Refresh the last-use time on a hit, set it on an insert.
    if (do_hit || do_insert) begin
      entry_stamp <= tok_in.now_stamp;
    end
  end

endmodule

@@ rtl/nat_mapping_table.sv @@
`timescale 1ns / 1ps
// NAT mapping table: a row of TABLE_ENTRIES slot cells and a response register.
// Depends on nmt_pkg, nmt_req_if, nmt_rsp_if and nmt_cell.
//
// Usage: a request word on req (lookup by external port and type, lookup by
// internal address, port and type, or insert into the lowest free slot) enters
// cell 0 and walks one cell per cycle down the row, slot 0 first. The first
// cell that matches (or, for an insert, the first free one) serves the word,
// refreshes or writes its stamp, and the rest of the row passes it along.
// After the last cell the word lands in the response register on rsp with
// status hit, miss, inserted or table full; on miss or full the found fields
// are zero.
// Each accepted word passes through the TABLE_ENTRIES cell registers in order
// and then the response register. Words follow each other down the row in
// order, so a new request is taken every cycle while rsp does not stall, and
// later words see every change made by earlier ones.
// Reset clears all slot valid marks, the tokens in flight and the response.
// When rsp stalls with a word held, the whole row holds and req.ready drops.
module nat_mapping_table #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic clk,
  input  logic rst,
  nmt_req_if.sink   req,
  nmt_rsp_if.source rsp
);

  nmt_pkg::tok_t tok [0:TABLE_ENTRIES];
  nmt_pkg::tok_t last;
  logic          advance;

  assign advance   = !rsp.valid || rsp.ready;
  assign req.ready = advance;

  assign tok[0] = '{valid:      req.valid,
                    done:       1'b0,
                    status:     nmt_pkg::ST_MISS,
                    opcode:     req.opcode,
                    map_type:   req.map_type,
                    inner_addr: req.inner_addr,
                    inner_port: req.inner_port,
                    outer_addr: req.outer_addr,
                    outer_port: req.outer_port,
                    now_stamp:  req.now_stamp};

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    nmt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  assign last = tok[TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (advance) begin
      rsp.valid <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (last.done) begin
        rsp.status           <= last.status;
        rsp.found_type       <= last.map_type;
        rsp.found_inner_addr <= last.inner_addr;
        rsp.found_inner_port <= last.inner_port;
        rsp.found_outer_addr <= last.outer_addr;
        rsp.found_outer_port <= last.outer_port;
        rsp.found_stamp      <= last.now_stamp;
      end else begin
        // Nobody served the word: full on insert, miss otherwise.
        rsp.status           <= (last.opcode == nmt_pkg::OP_INSERT) ? nmt_pkg::ST_FULL
                                                                    : nmt_pkg::ST_MISS;
        rsp.found_type       <= 1'b0;
        rsp.found_inner_addr <= '0;
        rsp.found_inner_port <= '0;
        rsp.found_outer_addr <= '0;
        rsp.found_outer_port <= '0;
        rsp.found_stamp      <= '0;
      end
    end
  end

endmodule

@@ tb/tb_nat_mapping_table.sv @@
`timescale 1ns / 1ps
// Self-checking bench for nat_mapping_table: directed rows, then random translation traffic.
// Depends on nmt_pkg, nmt_req_if and nmt_rsp_if; predicts every response word in-bench.
module tb_nat_mapping_table;

  localparam int TABLE_ENTRIES = 16;
  localparam int RANDOM_ITEMS  = 1426;
  localparam int STEADY_ITEMS  = 200;
  localparam int IDLE_LIMIT    = 1000;
  localparam logic [nmt_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic                        map_type;
    logic [nmt_pkg::ADDR_W-1:0]  inner_addr;
    logic [nmt_pkg::PORT_W-1:0]  inner_port;
    logic [nmt_pkg::ADDR_W-1:0]  outer_addr;
    logic [nmt_pkg::PORT_W-1:0]  outer_port;
    logic [nmt_pkg::STAMP_W-1:0] stamp;
  } nat_entry_t;

  typedef struct packed {
    logic [nmt_pkg::OP_W-1:0] opcode;
    nat_entry_t               entry;
  } nat_request_t;

  typedef struct packed {
    logic [nmt_pkg::ST_W-1:0] status;
    nat_entry_t               entry;
  } nat_result_t;

  typedef struct {
    nat_request_t req;
    bit           typed;
    nat_result_t  want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  nmt_req_if req ();
  nmt_rsp_if rsp ();

  nat_mapping_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the translation table.
  bit         slot_valid [TABLE_ENTRIES];
  nat_entry_t slot_map   [TABLE_ENTRIES];

  nat_result_t pending_results[$];
  int          mismatches = 0;
  int          requests_sent = 0;
  int          results_seen = 0;
  int          status_seen [4];
  bit          steady = 1'b0;
  int          idle_cycles = 0;
  int          stall_left = 0;

  function automatic nat_request_t mk_req(logic [nmt_pkg::OP_W-1:0] op, logic typ,
                                          logic [nmt_pkg::ADDR_W-1:0] ia,
                                          logic [nmt_pkg::PORT_W-1:0] ip,
                                          logic [nmt_pkg::ADDR_W-1:0] oa,
                                          logic [nmt_pkg::PORT_W-1:0] op_port,
                                          logic [nmt_pkg::STAMP_W-1:0] now);
    nat_request_t r;
    r.opcode = op;
    r.entry  = '{map_type: typ, inner_addr: ia, inner_port: ip, outer_addr: oa,
                 outer_port: op_port, stamp: now};
    return r;
  endfunction

  // Apply one request to the mirror and return the response word it yields.
  function automatic nat_result_t translate(nat_request_t r);
    nat_result_t res;
    int          slot;
    bit          match;
    res = '0;
    res.status = nmt_pkg::ST_MISS;
    slot = -1;
    if (r.opcode == nmt_pkg::OP_LOOKUP_OUTER || r.opcode == nmt_pkg::OP_LOOKUP_INNER) begin
      for (int i = 0; i < TABLE_ENTRIES && slot < 0; i++) begin
        if (slot_valid[i] && slot_map[i].map_type == r.entry.map_type) begin
          if (r.opcode == nmt_pkg::OP_LOOKUP_OUTER)
            match = slot_map[i].outer_port == r.entry.outer_port;
          else
            match = slot_map[i].inner_addr == r.entry.inner_addr &&
                    slot_map[i].inner_port == r.entry.inner_port;
          if (match) slot = i;
        end
      end
      if (slot >= 0) begin
        slot_map[slot].stamp = r.entry.stamp;
        res.status = nmt_pkg::ST_HIT;
      end
    end else if (r.opcode == nmt_pkg::OP_INSERT) begin
      res.status = nmt_pkg::ST_FULL;
      for (int i = 0; i < TABLE_ENTRIES && slot < 0; i++) begin
        if (!slot_valid[i]) slot = i;
      end
      if (slot >= 0) begin
        slot_valid[slot] = 1'b1;
        slot_map[slot]   = r.entry;
        res.status = nmt_pkg::ST_INSERTED;
      end
    end
    if (slot >= 0) res.entry = slot_map[slot];
    return res;
  endfunction

  task automatic send(nat_request_t r, bit typed, nat_result_t want);
    nat_result_t pred;
    if (!steady && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.opcode     <= r.opcode;
    req.map_type   <= r.entry.map_type;
    req.inner_addr <= r.entry.inner_addr;
    req.inner_port <= r.entry.inner_port;
    req.outer_addr <= r.entry.outer_addr;
    req.outer_port <= r.entry.outer_port;
    req.now_stamp  <= r.entry.stamp;
    do @(posedge clk); while (!req.ready);
    pred = translate(r);
    pending_results.push_back(typed ? want : pred);
    requests_sent++;
  endtask

  task automatic check_response(nat_result_t want, nat_result_t got);
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      mismatches++;
    end
    if (got.entry.map_type !== want.entry.map_type) begin
      $error("found_type: expected %0d, got %0d", want.entry.map_type, got.entry.map_type);
      mismatches++;
    end
    if (got.entry.inner_addr !== want.entry.inner_addr) begin
      $error("found_inner_addr: expected %h, got %h", want.entry.inner_addr,
             got.entry.inner_addr);
      mismatches++;
    end
    if (got.entry.inner_port !== want.entry.inner_port) begin
      $error("found_inner_port: expected %h, got %h", want.entry.inner_port,
             got.entry.inner_port);
      mismatches++;
    end
    if (got.entry.outer_addr !== want.entry.outer_addr) begin
      $error("found_outer_addr: expected %h, got %h", want.entry.outer_addr,
             got.entry.outer_addr);
      mismatches++;
    end
    if (got.entry.outer_port !== want.entry.outer_port) begin
      $error("found_outer_port: expected %h, got %h", want.entry.outer_port,
             got.entry.outer_port);
      mismatches++;
    end
    if (got.entry.stamp !== want.entry.stamp) begin
      $error("found_stamp: expected %h, got %h", want.entry.stamp, got.entry.stamp);
      mismatches++;
    end
  endtask

  // Response side: random stall bursts, none once the run turns steady.
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      rsp.ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!steady && $urandom_range(0, 5) == 0) begin
      rsp.ready  <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    nat_result_t got;
    if (!rst && rsp.valid && rsp.ready) begin
      got = {rsp.status, rsp.found_type, rsp.found_inner_addr, rsp.found_inner_port,
             rsp.found_outer_addr, rsp.found_outer_port, rsp.found_stamp};
      results_seen++;
      status_seen[got.status]++;
      if (pending_results.size() == 0) begin
        $error("response word with nothing pending: status %0d", got.status);
        mismatches++;
      end else begin
        check_response(pending_results.pop_front(), got);
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    stim_row_t    rows[$];
    stim_row_t    row;
    nat_request_t r;
    int           pick;
    int           k;
    int           sel;

    req.valid      = 1'b0;
    req.opcode     = nmt_pkg::OP_LOOKUP_OUTER;
    req.map_type   = 1'b0;
    req.inner_addr = '0;
    req.inner_port = '0;
    req.outer_addr = '0;
    req.outer_port = '0;
    req.now_stamp  = '0;
    for (int i = 0; i < 4; i++) status_seen[i] = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      slot_valid[i] = 1'b0;
      slot_map[i]   = '0;
    end

    // Empty table: every lookup and the unused opcode miss with zero fields.
    row = '{mk_req(nmt_pkg::OP_LOOKUP_OUTER, 1'b0, '0, '0, '0, '0, '0), 1'b1,
            '{nmt_pkg::ST_MISS, '0}};
    rows.push_back(row);
    row = '{mk_req(nmt_pkg::OP_LOOKUP_INNER, 1'b1, '1, '1, '1, '1, '1), 1'b1,
            '{nmt_pkg::ST_MISS, '0}};
    rows.push_back(row);
    row = '{mk_req(OP_UNUSED, 1'b1, '1, '1, '1, '1, '1), 1'b1, '{nmt_pkg::ST_MISS, '0}};
    rows.push_back(row);
    // Extremes, then a duplicate of the all-ones keys in the next slot.
    r = mk_req(nmt_pkg::OP_INSERT, 1'b0, '0, '0, '0, '0, '0);
    row = '{r, 1'b1, '{nmt_pkg::ST_INSERTED, r.entry}};
    rows.push_back(row);
    r = mk_req(nmt_pkg::OP_INSERT, 1'b1, '1, '1, '1, '1, '1);
    row = '{r, 1'b1, '{nmt_pkg::ST_INSERTED, r.entry}};
    rows.push_back(row);
    r = mk_req(nmt_pkg::OP_INSERT, 1'b1, '1, '1, '0, '1, 32'd1);
    row = '{r, 1'b1, '{nmt_pkg::ST_INSERTED, r.entry}};
    rows.push_back(row);
    for (int i = 3; i < TABLE_ENTRIES; i++) begin
      row = '{mk_req(nmt_pkg::OP_INSERT, 1'($urandom_range(0, 1)), $urandom(),
                     16'($urandom_range(0, 65535)), $urandom(),
                     16'($urandom_range(0, 65535)), $urandom()), 1'b0, '0};
      rows.push_back(row);
    end
    row = '{mk_req(nmt_pkg::OP_INSERT, 1'b0, '1, '0, '1, '0, '1), 1'b1,
            '{nmt_pkg::ST_FULL, '0}};
    rows.push_back(row);
    // Duplicates present: the lower slot must answer and get its stamp refreshed.
    row = '{mk_req(nmt_pkg::OP_LOOKUP_OUTER, 1'b1, '0, '0, '0, '1, 32'h0000_0100), 1'b0, '0};
    rows.push_back(row);
    row = '{mk_req(nmt_pkg::OP_LOOKUP_INNER, 1'b1, '1, '1, '0, '0, 32'h8000_0000), 1'b0, '0};
    rows.push_back(row);
    row = '{mk_req(nmt_pkg::OP_LOOKUP_OUTER, 1'b1, '1, '1, '1, '0, 32'h0000_0200), 1'b0, '0};
    rows.push_back(row);
    row = '{mk_req(nmt_pkg::OP_LOOKUP_INNER, 1'b0, '0, '0, '1, '1, 32'h1234_5678), 1'b0, '0};
    rows.push_back(row);
    row = '{mk_req(nmt_pkg::OP_LOOKUP_OUTER, 1'b0, '1, '1, '1, '0, 32'hfedc_ba98), 1'b0, '0};
    rows.push_back(row);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send(rows[i].req, rows[i].typed, rows[i].want);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n >= RANDOM_ITEMS - STEADY_ITEMS) steady = 1'b1;
      r = mk_req(OP_UNUSED, 1'($urandom_range(0, 1)), $urandom(),
                 16'($urandom_range(0, 65535)), $urandom(),
                 16'($urandom_range(0, 65535)), $urandom());
      pick = $urandom_range(0, 99);
      k    = $urandom_range(0, TABLE_ENTRIES - 1);
      sel  = $urandom_range(0, 9);
      if (pick < 75) begin
        r.opcode = (pick < 40) ? nmt_pkg::OP_LOOKUP_OUTER : nmt_pkg::OP_LOOKUP_INNER;
        // Mostly reuse stored keys; sometimes flip the type or nudge the port.
        if (sel < 9) begin
          r.entry.map_type   = slot_map[k].map_type ^ (sel == 7);
          r.entry.outer_port = slot_map[k].outer_port + 16'(sel == 8);
          r.entry.inner_addr = slot_map[k].inner_addr;
          r.entry.inner_port = slot_map[k].inner_port + 16'(sel == 8);
        end
      end else if (pick < 90) begin
        r.opcode = nmt_pkg::OP_INSERT;
      end
      send(r, 1'b0, '0);
    end
    req.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TABLE_ENTRIES + 4) @(posedge clk);

    $display("Sent %0d requests (%0d directed), checked %0d response words",
             requests_sent, rows.size(), results_seen);
    $display("Outcomes: %0d hit, %0d miss, %0d inserted, %0d table full",
             status_seen[nmt_pkg::ST_HIT], status_seen[nmt_pkg::ST_MISS],
             status_seen[nmt_pkg::ST_INSERTED], status_seen[nmt_pkg::ST_FULL]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
